// File: design/free_bitmap_allocator_unit_macros.svh
// Assertion macros for the free bitmap allocator.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
// Defining NO_ASSERTIONS turns every use into nothing.
`ifndef FREE_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define FREE_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define FBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define FBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FBA_ASSERT_NOW(lbl, ante, cons, msg)
`define FBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/fba_pkg.sv
package fba_pkg;

    localparam int MAP_BITS_DEF  = 4096;
    localparam int GROUP_LEN_DEF = 8;
    localparam int WORD_BITS     = 8;
    localparam int WORD_LSB      = $clog2(WORD_BITS);

    localparam int COUNT_W  = 13;
    localparam int POS_W    = 12;
    localparam int FCOUNT_W = 4;
    localparam int BASE_W   = COUNT_W + 1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

    typedef logic [WORD_BITS-1:0] word_t;

    localparam word_t FULL_WORD = 8'hFF;

    typedef enum logic [1:0] {
        ACT_TEST  = 2'd0,
        ACT_SET   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_FIND  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_RANGE     = 2'd1,
        STS_WAS_SET   = 2'd2,
        STS_WAS_CLEAR = 2'd3
    } status_t;

    // Result of a lowest-clear-bit search over one map word.
    typedef struct packed {
        logic                found;
        logic [WORD_LSB-1:0] index;
    } scan_t;

endpackage

// File: design/free_bitmap_allocator_unit.sv
// Free bitmap allocator. The map of used positions is held in a single-port-read,
// single-port-write memory of byte-wide words (MAP_BITS / 8 entries) with a registered
// read, next to a hint register that points at the first byte that may still hold a
// clear bit. Every transfer on the item channel is one test, set, clear or find.
// Test, set and clear read the word when the item is accepted, then in ST_RMW return the
// result and write the modified word back; no new item is taken before that is done.
// A find is accepted in ST_IDLE, loads each word from the hint upward in ST_LOAD, picks
// each free position in ST_PICK, steps past each word that is not full unless the group
// fills inside it, notices the end of the count when the scan runs that far, and then
// delivers its results in ST_EMIT (at least one); each word visited is read once through
// the memory read port. Results leave through an output register, so the block can take
// the next item and start on it while the previous result still waits on result_stall.
// After reset, and after each write of element_count, the block sweeps the memory to
// zero, one word per cycle (512 words at the default map size); item_stall stays high
// during that sweep, while writes to element_count are still taken and restart it.
// element_count may only be written while no item is in flight and no result is pending.
`include "free_bitmap_allocator_unit_macros.svh"

module free_bitmap_allocator_unit #(
    parameter int MAP_BITS  = fba_pkg::MAP_BITS_DEF,
    parameter int GROUP_LEN = fba_pkg::GROUP_LEN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           element_count_we,
    input  logic [fba_pkg::COUNT_W-1:0]    element_count,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [1:0]                     action,
    input  logic [fba_pkg::POS_W-1:0]      position,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [1:0]                     status,
    output logic                           bit_value,
    output logic [fba_pkg::POS_W-1:0]      free_index,
    output logic [fba_pkg::FCOUNT_W-1:0]   free_count,
    output logic                           last
);
    import fba_pkg::*;

    localparam int WORD_COUNT = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int HW         = $clog2(WORD_COUNT + 1);
    localparam int NW         = $clog2(GROUP_LEN + 1);
    localparam int IDX_W      = (GROUP_LEN > 1) ? $clog2(GROUP_LEN) : 1;

    localparam logic [AW-1:0] LAST_ADDR = AW'(WORD_COUNT - 1);
    localparam logic [NW-1:0] GROUP_TOP = NW'(GROUP_LEN);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_RMW   = 6'b000100,
        ST_LOAD  = 6'b001000,
        ST_PICK  = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    // Control state.
    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [HW-1:0]        hint_reg, hint_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic [NW-1:0]        n_reg, n_next;
    logic                 res_valid_reg, res_valid_next;

    // Item working state.
    action_t              act_reg, act_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [BASE_W-1:0]    base_reg, base_next;
    logic                 leading_reg, leading_next;
    word_t                work_reg, work_next;
    logic [IDX_W-1:0]     emit_reg, emit_next;
    logic [POS_W-1:0]     found_reg [GROUP_LEN];

    // Output payload.
    status_t              res_status_reg, res_status_next;
    logic                 res_bit_reg, res_bit_next;
    logic [POS_W-1:0]     res_index_reg, res_index_next;
    logic [FCOUNT_W-1:0]  res_count_reg, res_count_next;
    logic                 res_last_reg, res_last_next;

    // Map memory.
    word_t                map_mem [WORD_COUNT];
    word_t                rdata_reg;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    word_t                wr_data;

    // Combinational helpers.
    logic [COUNT_W-1:0]   limit;
    logic                 accept;
    logic                 res_free;
    logic [31:0]          in_word32;
    logic [31:0]          pos_word32;
    logic [31:0]          hint_base32;
    logic [31:0]          step_word32;
    logic [BASE_W-1:0]    base_step;
    logic [BASE_W-1:0]    limit_ext;
    logic [WORD_LSB-1:0]  pos_bit;
    word_t                bit_mask;
    logic                 bit_is_set;
    logic                 in_range;
    word_t                oob_mask;
    logic                 word_full;
    scan_t                scan;
    logic [BASE_W-1:0]    pick_pos;
    logic                 found_we;
    logic [31:0]          n32;
    logic                 emit_last;

    // Positions at or above the effective count are out of range; the effective count never
    // exceeds the size of the map.
    always_comb
    begin
        if (32'(count_reg) > MAP_BITS)
            limit = COUNT_W'(MAP_BITS);
        else
            limit = count_reg;
    end

    assign limit_ext   = BASE_W'(limit);
    assign accept      = item_valid && (state_reg == ST_IDLE);
    assign item_stall  = (state_reg != ST_IDLE);
    assign res_free    = !res_valid_reg || !result_stall;

    assign in_word32   = 32'(position) >> WORD_LSB;
    assign pos_word32  = 32'(pos_reg) >> WORD_LSB;
    assign hint_base32 = 32'(hint_reg) << WORD_LSB;
    assign base_step   = base_reg + BASE_W'(WORD_BITS);
    assign step_word32 = 32'(base_step) >> WORD_LSB;

    assign pos_bit     = pos_reg[WORD_LSB-1:0];
    assign bit_mask    = word_t'(1) << pos_bit;
    assign bit_is_set  = rdata_reg[pos_bit];
    assign in_range    = COUNT_W'(pos_reg) < limit;

    // Bits beyond the count are treated as used, so a partly covered last word never
    // yields a position outside the range.
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
            oob_mask[i] = (base_reg + BASE_W'(i)) >= limit_ext;
    end

    // A word only counts as full, and only lets the hint move past it, when it lies
    // wholly inside the count.
    assign word_full = (base_step <= limit_ext) && (rdata_reg == FULL_WORD);

    fba_word_scan u_scan (
        .word (work_reg),
        .scan (scan)
    );

    assign pick_pos  = base_reg + BASE_W'(scan.index);
    assign n32       = 32'(n_reg);
    assign emit_last = (32'(emit_reg) + 32'd1) == n32;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        hint_next       = hint_reg;
        clr_addr_next   = clr_addr_reg;
        n_next          = n_reg;
        act_next        = act_reg;
        pos_next        = pos_reg;
        base_next       = base_reg;
        leading_next    = leading_reg;
        work_next       = work_reg;
        emit_next       = emit_reg;
        res_valid_next  = res_valid_reg && result_stall;
        res_status_next = res_status_reg;
        res_bit_next    = res_bit_reg;
        res_index_next  = res_index_reg;
        res_count_next  = res_count_reg;
        res_last_next   = res_last_reg;
        rd_addr         = step_word32[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = clr_addr_reg;
        wr_data         = '0;
        found_we        = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
                if (clr_addr_reg == LAST_ADDR)
                    state_next = ST_IDLE;
                else
                    clr_addr_next = clr_addr_reg + AW'(1);
            end

            ST_IDLE:
            begin
                if (action_t'(action) == ACT_FIND)
                    rd_addr = AW'(hint_reg);
                else
                    rd_addr = in_word32[AW-1:0];
                if (accept)
                begin
                    act_next = action_t'(action);
                    pos_next = position;
                    if (action_t'(action) == ACT_FIND)
                    begin
                        base_next    = hint_base32[BASE_W-1:0];
                        leading_next = 1'b1;
                        n_next       = '0;
                        emit_next    = '0;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_RMW;
                    end
                end
            end

            ST_RMW:
            begin
                // Hold the address so the read data stays valid while the output waits.
                rd_addr = pos_word32[AW-1:0];
                wr_addr = pos_word32[AW-1:0];
                if (res_free)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = STS_OK;
                    res_bit_next    = 1'b0;
                    res_index_next  = '0;
                    res_count_next  = '0;
                    res_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                    if (!in_range)
                    begin
                        res_status_next = STS_RANGE;
                    end
                    else
                    begin
                        unique case (act_reg)
                            ACT_TEST:
                            begin
                                res_bit_next = bit_is_set;
                            end
                            ACT_SET:
                            begin
                                if (bit_is_set)
                                begin
                                    res_status_next = STS_WAS_SET;
                                end
                                else
                                begin
                                    wr_en   = 1'b1;
                                    wr_data = rdata_reg | bit_mask;
                                end
                            end
                            ACT_CLEAR:
                            begin
                                if (!bit_is_set)
                                begin
                                    res_status_next = STS_WAS_CLEAR;
                                end
                                else
                                begin
                                    wr_en   = 1'b1;
                                    wr_data = rdata_reg & ~bit_mask;
                                    // Freeing a bit below the hint pulls the hint back.
                                    if (pos_word32 < 32'(hint_reg))
                                        hint_next = HW'(pos_word32);
                                end
                            end
                            default:
                            begin
                                res_status_next = STS_OK;
                            end
                        endcase
                    end
                end
            end

            ST_LOAD:
            begin
                if (base_reg >= limit_ext)
                begin
                    state_next = ST_EMIT;
                end
                else if (word_full)
                begin
                    // Skip a full word; the hint follows only while no open word was seen.
                    if (leading_reg)
                        hint_next = HW'(step_word32);
                    base_next = base_step;
                end
                else
                begin
                    leading_next = 1'b0;
                    work_next    = rdata_reg | oob_mask;
                    state_next   = ST_PICK;
                end
            end

            ST_PICK:
            begin
                if (scan.found)
                begin
                    found_we  = 1'b1;
                    n_next    = n_reg + NW'(1);
                    work_next = work_reg | (word_t'(1) << scan.index);
                    if ((n_reg + NW'(1)) == GROUP_TOP)
                        state_next = ST_EMIT;
                end
                else
                begin
                    base_next  = base_step;
                    state_next = ST_LOAD;
                end
            end

            ST_EMIT:
            begin
                if (res_free)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = STS_OK;
                    res_bit_next    = 1'b0;
                    if (n_reg == '0)
                    begin
                        res_index_next = '0;
                        res_count_next = '0;
                        res_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        res_index_next = found_reg[emit_reg];
                        res_count_next = n32[FCOUNT_W-1:0];
                        res_last_next  = emit_last;
                        emit_next      = emit_reg + IDX_W'(1);
                        if (emit_last)
                            state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A new count empties the map: sweep the memory and restart the hint.
        if (element_count_we)
        begin
            count_next    = element_count;
            hint_next     = '0;
            clr_addr_next = '0;
            state_next    = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            count_reg     <= COUNT_RESET;
            hint_reg      <= '0;
            clr_addr_reg  <= '0;
            n_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            hint_reg      <= hint_next;
            clr_addr_reg  <= clr_addr_next;
            n_reg         <= n_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        pos_reg        <= pos_next;
        base_reg       <= base_next;
        leading_reg    <= leading_next;
        work_reg       <= work_next;
        emit_reg       <= emit_next;
        res_status_reg <= res_status_next;
        res_bit_reg    <= res_bit_next;
        res_index_reg  <= res_index_next;
        res_count_reg  <= res_count_next;
        res_last_reg   <= res_last_next;
        if (found_we)
            found_reg[n_reg[IDX_W-1:0]] <= pick_pos[POS_W-1:0];
    end

    // The map memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            map_mem[wr_addr] <= wr_data;
        rdata_reg <= map_mem[rd_addr];
    end

    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign bit_value    = res_bit_reg;
    assign free_index   = res_index_reg;
    assign free_count   = res_count_reg;
    assign last         = res_last_reg;

    `FBA_ASSERT_NOW(a_hint_in_range, 1'b1, (32'(hint_reg) <= (32'(limit) >> WORD_LSB)), "hint past count")
    `FBA_ASSERT_NOW(a_group_bound, 1'b1, (32'(n_reg) <= GROUP_LEN), "group overfilled")
    `FBA_ASSERT_NOW(a_rmw_not_find, (state_reg == ST_RMW), (act_reg != ACT_FIND), "find in RMW")
    `FBA_ASSERT_NEXT(a_sweep_ends, ((state_reg == ST_CLEAR) && (clr_addr_reg == LAST_ADDR) && !element_count_we), (state_reg == ST_IDLE), "sweep end")

endmodule

// File: design/fba_word_scan.sv
module fba_word_scan (
    input  fba_pkg::word_t word,
    output fba_pkg::scan_t scan
);
    import fba_pkg::*;

    // Priority encoder: walking down from the top leaves the lowest clear bit.
    always_comb
    begin
        scan = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                scan.found = 1'b1;
                scan.index = WORD_LSB'(i);
            end
        end
    end

endmodule
